// ----- sv/refcounted_space_slot_table_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the slot table unit
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_SPACE_SLOT_TABLE_UNIT_MACROS_SVH
`define REFCOUNTED_SPACE_SLOT_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define RSST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot table assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define RSST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot table assertion failed");
`else
`define RSST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RSST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/rsst_pkg.sv -----
// ----------------------------------------------------------------------------
// rsst_pkg
// Types, codes and field layout shared by the slot table modules.
// ----------------------------------------------------------------------------
package rsst_pkg;

    // Sizes and field layout.
    localparam int SLOT_COUNT_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int CNT_W          = 5;
    localparam int IN_W           = 48;
    localparam int OUT_W          = 64;
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 1;
    localparam logic [15:0] RC_MAX = 16'hFFFF;

    // Operation codes; the two unused codes fall to a default arm.
    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_FORK     = 3'd1,
        OP_RETAIN   = 3'd2,
        OP_RELEASE  = 3'd3,
        OP_GET      = 3'd4,
        OP_SNAPSHOT = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_KIND = 1'b0,
        REG_KERNEL_ID   = 1'b1
    } t_cfg_reg;

    // Which result the datapath loads into its output register.
    typedef enum logic [1:0] {
        EM_NONE = 2'd0,
        EM_FAIL = 2'd1,
        EM_NEW  = 2'd2,
        EM_SLOT = 2'd3
    } t_emit;

    // Count update applied to a slot that is reported.
    typedef enum logic [1:0] {
        UPD_KEEP = 2'd0,
        UPD_BUMP = 2'd1,
        UPD_DEC  = 2'd2
    } t_upd;

    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_FREE      = 3'd1,
        S_SCAN      = 3'd2,
        S_CHECK     = 3'd3,
        S_ACT       = 3'd4,
        S_LIST      = 3'd5,
        S_LIST_EMIT = 3'd6,
        S_FAIL      = 3'd7
    } t_state;

    // One slot entry as held in the slot memory.
    typedef struct packed {
        logic [15:0] refcount;
        logic [7:0]  kind;
        logic [31:0] id;
    } t_slot;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    rd_en;
        logic    idx_inc;
        logic    idx_clr;
        logic    fail_load;
        t_status fail_code;
        t_emit   emit;
        t_upd    upd;
        logic    emit_last;
        logic    take_kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  in_op;
        logic in_maxc_zero;
        t_op  op;
        logic used_here;
        logic id_hit;
        logic kind_kernel;
        logic idx_end;
        logic out_free;
        logic list_done;
    } t_stat;

endpackage

// ----- sv/refcounted_space_slot_table_unit.sv -----
// ----------------------------------------------------------------------------
// refcounted_space_slot_table_unit
// Reference-counted table of address-space slots with create, fork, retain,
// release, get and snapshot operations.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake             Payload
//  s_axis    in   tvalid / tready       opcode, space_id, kind, max_count
//  m_axis    out  tvalid / tready       status, id, kind, refcount, isolated; tlast
//  cfg       in   write enable only     register index, write data
//
//  One operation at a time; slots are walked one per cycle, and each used slot
//  that a lookup or snapshot examines is first read from the slot memory.
//  A stalled output holds the report step; the next word is taken after the last load.
//  Synchronous reset frees all slots, next id 1, kernel kind 0, kernel id 1.
// ----------------------------------------------------------------------------
module refcounted_space_slot_table_unit #(
    parameter int SLOT_COUNT = rsst_pkg::SLOT_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [2:0] opcode, [34:3] space_id, [42:35] kind, [47:43] max_count
    input  logic [rsst_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [1:0] status, [33:2] result_id, [41:34] result_kind,
    // [57:42] result_refcount, [58] isolated, [63:59] zero
    output logic [rsst_pkg::OUT_W-1:0]     o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [rsst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rsst_pkg::CFG_W-1:0]     i_cfg_data
);
    import rsst_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer.
    rsst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Table datapath.
    rsst_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

// ----- sv/rsst_ram.sv -----
// ----------------------------------------------------------------------------
// rsst_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rsst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/rsst_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsst_ctrl
// Sequencer for the slot table: walks the slots one per step and tells the
// datapath when to read, update and report.
// ----------------------------------------------------------------------------
module rsst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rsst_pkg::t_stat i_stat,
    output rsst_pkg::t_cmd  o_cmd
);
    import rsst_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_stat.in_op)
                        OP_CREATE:   n_state = S_FREE;
                        OP_FORK:     n_state = S_SCAN;
                        OP_RETAIN:   n_state = S_SCAN;
                        OP_RELEASE:  n_state = S_SCAN;
                        OP_GET:      n_state = S_SCAN;
                        OP_SNAPSHOT: n_state = i_stat.in_maxc_zero ? S_FAIL : S_LIST;
                        default:     n_state = S_FAIL;
                    endcase
                end
            end
            S_FREE: begin
                if (!i_stat.used_here) begin
                    if (i_stat.out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (i_stat.idx_end) begin
                    n_state = S_FAIL;
                end
            end
            S_SCAN: begin
                if (i_stat.used_here) begin
                    n_state = S_CHECK;
                end else if (i_stat.idx_end) begin
                    n_state = S_FAIL;
                end
            end
            S_CHECK: begin
                if (i_stat.id_hit) begin
                    n_state = S_ACT;
                end else if (i_stat.idx_end) begin
                    n_state = S_FAIL;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_ACT: begin
                if (i_stat.op == OP_FORK && !i_stat.kind_kernel) begin
                    n_state = S_FREE;
                end else if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_stat.used_here) begin
                    n_state = S_LIST_EMIT;
                end else if (i_stat.idx_end) begin
                    n_state = S_FAIL;
                end
            end
            S_LIST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.list_done ? S_IDLE : S_LIST;
                end
            end
            S_FAIL: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath. Ready stays low while reset is asserted.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_stat.in_op)
                        OP_CREATE, OP_FORK, OP_RETAIN, OP_RELEASE, OP_GET: begin
                        end
                        OP_SNAPSHOT: begin
                            o_cmd.fail_load = i_stat.in_maxc_zero;
                            o_cmd.fail_code = STS_EMPTY;
                        end
                        default: begin
                            o_cmd.fail_load = 1'b1;
                            o_cmd.fail_code = STS_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_FREE: begin
                if (!i_stat.used_here) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = EM_NEW;
                        o_cmd.emit_last = 1'b1;
                    end
                end else if (i_stat.idx_end) begin
                    o_cmd.fail_load = 1'b1;
                    o_cmd.fail_code = STS_FULL;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_stat.used_here) begin
                    o_cmd.rd_en = 1'b1;
                end else if (i_stat.idx_end) begin
                    o_cmd.fail_load = 1'b1;
                    o_cmd.fail_code = STS_NOT_FOUND;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_CHECK: begin
                if (!i_stat.id_hit) begin
                    if (i_stat.idx_end) begin
                        o_cmd.fail_load = 1'b1;
                        o_cmd.fail_code = STS_NOT_FOUND;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_ACT: begin
                if (i_stat.op == OP_FORK && !i_stat.kind_kernel) begin
                    // A user-kind parent is copied into a fresh slot.
                    o_cmd.take_kind = 1'b1;
                    o_cmd.idx_clr   = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.emit      = EM_SLOT;
                    o_cmd.emit_last = 1'b1;
                    unique case (i_stat.op)
                        OP_FORK:    o_cmd.upd = UPD_BUMP;
                        OP_RETAIN:  o_cmd.upd = UPD_BUMP;
                        OP_RELEASE: o_cmd.upd = UPD_DEC;
                        default:    o_cmd.upd = UPD_KEEP;
                    endcase
                end
            end
            S_LIST: begin
                if (i_stat.used_here) begin
                    o_cmd.rd_en = 1'b1;
                end else if (i_stat.idx_end) begin
                    o_cmd.fail_load = 1'b1;
                    o_cmd.fail_code = STS_EMPTY;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_LIST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = EM_SLOT;
                    o_cmd.upd       = UPD_KEEP;
                    o_cmd.emit_last = i_stat.list_done;
                    o_cmd.idx_inc   = !i_stat.list_done;
                end
            end
            S_FAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = EM_FAIL;
                    o_cmd.emit_last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/rsst_dp.sv -----
// ----------------------------------------------------------------------------
// rsst_dp
// Slot table datapath: slot memory, used bits, id counter, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
`include "refcounted_space_slot_table_unit_macros.svh"

module rsst_dp #(
    parameter int SLOT_COUNT = rsst_pkg::SLOT_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rsst_pkg::IN_W-1:0]      i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rsst_pkg::OUT_W-1:0]     o_out_data,
    output logic                           o_out_last,
    input  logic                           i_cfg_we,
    input  logic [rsst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rsst_pkg::CFG_W-1:0]     i_cfg_data,
    input  rsst_pkg::t_cmd                 i_cmd,
    output rsst_pkg::t_stat                o_stat
);
    import rsst_pkg::*;

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_W = $bits(t_slot);

    // Operation registers.
    t_op              r_op;
    logic [31:0]      r_id;
    logic [7:0]       r_kind;
    logic [CNT_W-1:0] r_maxc;
    logic [CNT_W-1:0] r_nlist;
    logic [IDX_W-1:0] r_idx;
    t_status          r_fail;

    // Table state and configuration.
    logic [SLOT_COUNT-1:0] r_used;
    logic [31:0]           r_next_id;
    logic [7:0]            r_kernel_kind;
    logic [31:0]           r_kernel_id;

    // Output register.
    logic        r_out_valid;
    t_status     r_out_status;
    logic [31:0] r_out_id;
    logic [7:0]  r_out_kind;
    logic [15:0] r_out_rc;
    logic        r_out_iso;
    logic        r_out_last;

    t_status     n_out_status;
    logic [31:0] n_out_id;
    logic [7:0]  n_out_kind;
    logic [15:0] n_out_rc;

    // Input word fields.
    t_op              w_in_op;
    logic [31:0]      w_in_id;
    logic [7:0]       w_in_kind;
    logic [CNT_W-1:0] w_in_maxc;
    logic [CNT_W-1:0] w_in_maxc_cap;

    logic [SLOT_W-1:0] w_rdata;
    t_slot             w_slot;
    logic [15:0]       w_rc_new;
    logic              w_free;
    logic              w_above;
    logic              w_we;
    t_slot             w_wdata;

    assign w_in_op       = t_op'(i_in_data[2:0]);
    assign w_in_id       = i_in_data[34:3];
    assign w_in_kind     = i_in_data[42:35];
    assign w_in_maxc     = i_in_data[47:43];
    assign w_in_maxc_cap = (w_in_maxc > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : w_in_maxc;

    // Slot memory: read at the scan index, written when a slot is made or updated.
    rsst_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_slot = t_slot'(w_rdata);

    // Saturating count update for the slot being reported.
    always_comb begin
        unique case (i_cmd.upd)
            UPD_BUMP: w_rc_new = (w_slot.refcount == RC_MAX) ? w_slot.refcount
                                                              : w_slot.refcount + 16'd1;
            UPD_DEC:  w_rc_new = (w_slot.refcount == 16'd0) ? 16'd0
                                                             : w_slot.refcount - 16'd1;
            default:  w_rc_new = w_slot.refcount;
        endcase
    end

    // A release that reaches zero frees the slot, except for the kernel space.
    assign w_free = (i_cmd.emit == EM_SLOT) && (i_cmd.upd == UPD_DEC) &&
                    (w_rc_new == 16'd0) && (r_id != r_kernel_id);

    // Memory write data.
    always_comb begin
        if (i_cmd.emit == EM_NEW) begin
            w_we             = 1'b1;
            w_wdata.refcount = 16'd1;
            w_wdata.kind     = r_kind;
            w_wdata.id       = r_next_id;
        end else begin
            w_we             = (i_cmd.emit == EM_SLOT) && (i_cmd.upd != UPD_KEEP);
            w_wdata.refcount = w_rc_new;
            w_wdata.kind     = w_slot.kind;
            w_wdata.id       = w_slot.id;
        end
    end

    // Any used slot beyond the scan index, for the snapshot's last flag.
    always_comb begin
        w_above = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (r_used[i] && (IDX_W'(i) > r_idx)) begin
                w_above = 1'b1;
            end
        end
    end

    // Next output payload.
    always_comb begin
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_kind   = r_out_kind;
        n_out_rc     = r_out_rc;
        unique case (i_cmd.emit)
            EM_FAIL: begin
                n_out_status = r_fail;
                n_out_id     = 32'd0;
                n_out_kind   = 8'd0;
                n_out_rc     = 16'd0;
            end
            EM_NEW: begin
                n_out_status = STS_OK;
                n_out_id     = r_next_id;
                n_out_kind   = r_kind;
                n_out_rc     = 16'd1;
            end
            EM_SLOT: begin
                n_out_status = STS_OK;
                n_out_id     = w_slot.id;
                n_out_kind   = w_slot.kind;
                n_out_rc     = w_rc_new;
            end
            default: begin
            end
        endcase
    end

    // Control and table state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used        <= '0;
            r_next_id     <= 32'd1;
            r_kernel_kind <= 8'd0;
            r_kernel_id   <= 32'd1;
            r_out_valid   <= 1'b0;
            r_idx         <= '0;
            r_nlist       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_KERNEL_KIND: r_kernel_kind <= i_cfg_data[7:0];
                    REG_KERNEL_ID:   r_kernel_id   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.accept) begin
                r_nlist <= '0;
            end else if (i_cmd.emit == EM_SLOT) begin
                r_nlist <= r_nlist + CNT_W'(1);
            end
            if (i_cmd.emit == EM_NEW) begin
                r_used[r_idx] <= 1'b1;
                r_next_id     <= r_next_id + 32'd1;
            end
            if (w_free) begin
                r_used[r_idx] <= 1'b0;
            end
            if (i_cmd.emit != EM_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operation and output payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= w_in_op;
            r_id   <= w_in_id;
            r_kind <= w_in_kind;
            r_maxc <= w_in_maxc_cap;
        end else if (i_cmd.take_kind) begin
            r_kind <= w_slot.kind;
        end
        if (i_cmd.fail_load) begin
            r_fail <= i_cmd.fail_code;
        end
        if (i_cmd.emit != EM_NONE) begin
            r_out_status <= n_out_status;
            r_out_id     <= n_out_id;
            r_out_kind   <= n_out_kind;
            r_out_rc     <= n_out_rc;
            r_out_iso    <= (n_out_status == STS_OK) && (n_out_kind != r_kernel_kind);
            r_out_last   <= i_cmd.emit_last;
        end
    end

    // Status to the controller.
    assign o_stat.in_op        = w_in_op;
    assign o_stat.in_maxc_zero = (w_in_maxc == '0);
    assign o_stat.op           = r_op;
    assign o_stat.used_here    = r_used[r_idx];
    assign o_stat.id_hit       = (w_slot.id == r_id);
    assign o_stat.kind_kernel  = (w_slot.kind == r_kernel_kind);
    assign o_stat.idx_end      = (r_idx == IDX_W'(SLOT_COUNT - 1));
    assign o_stat.out_free     = !r_out_valid || i_out_ready;
    assign o_stat.list_done    = ((r_nlist + CNT_W'(1)) == r_maxc) || !w_above;

    // Output word.
    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {5'd0, r_out_iso, r_out_rc, r_out_kind, r_out_id, r_out_status};

    // A result is loaded only when the output register can take it.
    `RSST_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.emit != EM_NONE, o_stat.out_free)
    // A new space is only placed in a free slot.
    `RSST_ASSERT_IMP(a_new_free, i_clk, i_rst_n, i_cmd.emit == EM_NEW, !r_used[r_idx])
    // An existing slot is only reported while it is in use.
    `RSST_ASSERT_IMP(a_slot_used, i_clk, i_rst_n, i_cmd.emit == EM_SLOT, r_used[r_idx])
    // Each created space consumes exactly one id.
    `RSST_ASSERT_NXT(a_id_step, i_clk, i_rst_n, i_cmd.emit == EM_NEW,
                     r_next_id == $past(r_next_id) + 32'd1)

endmodule

// ----- verif/refcounted_space_slot_table_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot table unit testbench
// Drives create, fork, retain, release, get and snapshot requests into the
// slot table, keeps its own copy of the table to predict every result word,
// and compares each word taken from the output stream field by field. Both
// stream sides idle and stall at random. The kernel registers are rewritten
// between phases while the unit is quiet.
// ----------------------------------------------------------------------------
module refcounted_space_slot_table_unit_test;
    import rsst_pkg::*;

    localparam int          SLOTS        = SLOT_COUNT_DEF;
    // Opcodes outside the defined set; the unit must answer them with not found.
    localparam logic [2:0]  OP_SPARE_A   = 3'd6;
    localparam logic [2:0]  OP_SPARE_B   = 3'd7;
    // Worst request is a fork into a new slot.
    localparam int          SETTLE       = 4 * SLOTS;
    // About 210 requests with random gaps and stalls on up to 16 words,
    // plus the quiet waits between bursts.
    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam int          PRINT_LIMIT  = 40;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] space_id;
        logic [7:0]  kind;
        logic [4:0]  max_count;
    } t_space_req;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] id;
        logic [7:0]  kind;
        logic [15:0] refcount;
        logic        isolated;
        logic        last;
    } t_space_word;

    // Clock and reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Unit ports.
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    refcounted_space_slot_table_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // Shadow copy of the table and the kernel registers.
    logic        tbl_used [SLOTS];
    logic [31:0] tbl_id   [SLOTS];
    logic [7:0]  tbl_kind [SLOTS];
    logic [15:0] tbl_rc   [SLOTS];
    logic [31:0] tbl_next_id     = 32'd1;
    logic [7:0]  cfg_kernel_kind = 8'd0;
    logic [31:0] cfg_kernel_id   = 32'd1;

    t_space_req  req_pending[$];
    t_space_req  req_live;
    t_space_word due_words[$];

    int unsigned req_gap    = 0;
    int unsigned word_stall = 0;
    int unsigned cycle_cnt  = 0;
    int          fail_cnt   = 0;
    bit          no_idle    = 1'b0;

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            tbl_used[s] = 1'b0;
            tbl_id[s]   = '0;
            tbl_kind[s] = '0;
            tbl_rc[s]   = '0;
        end
    end

    // Idle and stall lengths, drawn at random; mostly short.
    function automatic int unsigned draw_wait();
        if (no_idle)
            return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 2);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    // Table operations on the shadow copy.
    function automatic int find_space(logic [31:0] id);
        for (int s = 0; s < SLOTS; s++)
            if (tbl_used[s] && tbl_id[s] == id)
                return s;
        return -1;
    endfunction

    function automatic int alloc_slot(logic [7:0] kd);
        for (int s = 0; s < SLOTS; s++) begin
            if (!tbl_used[s]) begin
                tbl_used[s] = 1'b1;
                tbl_id[s]   = tbl_next_id;
                tbl_next_id = tbl_next_id + 32'd1;
                tbl_kind[s] = kd;
                tbl_rc[s]   = 16'd1;
                return s;
            end
        end
        return -1;
    endfunction

    function automatic void bump_count(int s);
        if (tbl_rc[s] != RC_MAX)
            tbl_rc[s] = tbl_rc[s] + 16'd1;
    endfunction

    function automatic void queue_slot_word(int s, logic last);
        t_space_word w;
        w.status   = STS_OK;
        w.id       = tbl_id[s];
        w.kind     = tbl_kind[s];
        w.refcount = tbl_rc[s];
        w.isolated = (tbl_kind[s] != cfg_kernel_kind);
        w.last     = last;
        due_words.push_back(w);
    endfunction

    function automatic void queue_fail_word(t_status st);
        t_space_word w;
        w.status   = st;
        w.id       = '0;
        w.kind     = '0;
        w.refcount = '0;
        w.isolated = 1'b0;
        w.last     = 1'b1;
        due_words.push_back(w);
    endfunction

    // Applies one accepted request to the shadow table and queues its words.
    function automatic void apply_space_op(t_space_req req);
        int s;
        int limit;
        int listed[$];
        case (req.op)
            OP_CREATE: begin
                s = alloc_slot(req.kind);
                if (s < 0) queue_fail_word(STS_FULL);
                else       queue_slot_word(s, 1'b1);
            end
            OP_FORK: begin
                s = find_space(req.space_id);
                if (s < 0) begin
                    queue_fail_word(STS_NOT_FOUND);
                end else if (tbl_kind[s] == cfg_kernel_kind) begin
                    // A kernel-kind parent is shared, not copied.
                    bump_count(s);
                    queue_slot_word(s, 1'b1);
                end else begin
                    s = alloc_slot(tbl_kind[s]);
                    if (s < 0) queue_fail_word(STS_FULL);
                    else       queue_slot_word(s, 1'b1);
                end
            end
            OP_RETAIN: begin
                s = find_space(req.space_id);
                if (s < 0) begin
                    queue_fail_word(STS_NOT_FOUND);
                end else begin
                    bump_count(s);
                    queue_slot_word(s, 1'b1);
                end
            end
            OP_RELEASE: begin
                s = find_space(req.space_id);
                if (s < 0) begin
                    queue_fail_word(STS_NOT_FOUND);
                end else begin
                    if (tbl_rc[s] != 16'd0)
                        tbl_rc[s] = tbl_rc[s] - 16'd1;
                    // The word reports the slot before it is cleared.
                    queue_slot_word(s, 1'b1);
                    if (tbl_rc[s] == 16'd0 && req.space_id != cfg_kernel_id) begin
                        tbl_used[s] = 1'b0;
                        tbl_id[s]   = '0;
                        tbl_kind[s] = '0;
                    end
                end
            end
            OP_GET: begin
                s = find_space(req.space_id);
                if (s < 0) queue_fail_word(STS_NOT_FOUND);
                else       queue_slot_word(s, 1'b1);
            end
            OP_SNAPSHOT: begin
                limit = (req.max_count > MAX_RESULTS) ? MAX_RESULTS : int'(req.max_count);
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_used[i] && listed.size() < limit)
                        listed.push_back(i);
                if (listed.size() == 0) begin
                    queue_fail_word(STS_EMPTY);
                end else begin
                    foreach (listed[k])
                        queue_slot_word(listed[k], k == listed.size() - 1);
                end
            end
            default: queue_fail_word(STS_NOT_FOUND);
        endcase
    endfunction

    // Request driver: sends queued requests, with random gaps between them.
    always @(posedge i_clk) begin : req_driver
        int unsigned gap;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            req_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_space_op(req_live);
                gap = draw_wait();
            end else begin
                gap = req_gap;
            end
            if (!s_tvalid || s_tready) begin
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    req_gap  <= gap - 1;
                end else if (req_pending.size() != 0) begin
                    req_live = req_pending.pop_front();
                    s_tdata  <= {req_live.max_count, req_live.kind,
                                 req_live.space_id, req_live.op};
                    s_tvalid <= 1'b1;
                    req_gap  <= 0;
                end else begin
                    s_tvalid <= 1'b0;
                    req_gap  <= 0;
                end
            end
        end
    end

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        if (fail_cnt <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Word monitor: takes result words with random stalls and checks them.
    always @(posedge i_clk) begin : word_monitor
        t_space_word want;
        int unsigned stall;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            word_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_words.size() == 0) begin
                    report_mismatch("result word with none expected");
                end else begin
                    want = due_words.pop_front();
                    check_field("status",   m_tdata[1:0],   want.status);
                    check_field("id",       m_tdata[33:2],  want.id);
                    check_field("kind",     m_tdata[41:34], want.kind);
                    check_field("refcount", m_tdata[57:42], want.refcount);
                    check_field("isolated", m_tdata[58],    want.isolated);
                    check_field("pad",      m_tdata[63:59], '0);
                    check_field("last",     m_tlast,        want.last);
                end
                stall = draw_wait();
            end else begin
                stall = word_stall;
            end
            if (stall != 0) begin
                m_tready   <= 1'b0;
                word_stall <= stall - 1;
            end else begin
                m_tready   <= 1'b1;
                word_stall <= 0;
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_req(input logic [2:0] op, input logic [31:0] id,
                             input logic [7:0] kd, input logic [4:0] maxc);
        t_space_req r;
        r.op        = op;
        r.space_id  = id;
        r.kind      = kd;
        r.max_count = maxc;
        req_pending.push_back(r);
    endtask

    // Waits until every request is taken and every word has come back.
    task automatic await_quiet();
        do @(negedge i_clk);
        while (req_pending.size() != 0 || s_tvalid || due_words.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] value);
        await_quiet();
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        if (idx == REG_KERNEL_KIND) cfg_kernel_kind = value[7:0];
        else                        cfg_kernel_id   = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly an id that is in the table right now, sometimes any id.
    function automatic logic [31:0] pick_live_id();
        logic [31:0] ids[$];
        for (int s = 0; s < SLOTS; s++)
            if (tbl_used[s])
                ids.push_back(tbl_id[s]);
        if (ids.size() == 0 || $urandom_range(0, 9) == 0)
            return $urandom;
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    function automatic int live_slot();
        int s;
        for (s = 0; s < SLOTS; s++)
            if (tbl_used[s])
                return s;
        return -1;
    endfunction

    task automatic queue_random_req(input int create_pct, input int release_pct);
        int          pick;
        logic [2:0]  op;
        logic [7:0]  kd;
        logic [31:0] id;
        pick = $urandom_range(0, 99);
        kd   = ($urandom_range(0, 2) == 0) ? cfg_kernel_kind : 8'($urandom);
        id   = pick_live_id();
        if (pick < create_pct) begin
            op = OP_CREATE;
        end else if (pick < create_pct + release_pct) begin
            op = OP_RELEASE;
        end else begin
            case ($urandom_range(0, 9))
                0, 1:    op = OP_FORK;
                2, 3:    op = OP_RETAIN;
                4, 5:    op = OP_GET;
                6, 7, 8: op = OP_SNAPSHOT;
                default: op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            endcase
        end
        queue_req(op, id, kd, 5'($urandom_range(0, 31)));
    endtask

    // Random requests in short bursts, each burst run until quiet.
    task automatic run_phase(input int items, input int create_pct, input int release_pct);
        int left;
        int burst;
        left = items;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (burst) queue_random_req(create_pct, release_pct);
            left -= burst;
            await_quiet();
        end
    endtask

    // Stimulus.
    initial begin : stimulus
        int s;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty table, create and fork of both kinds, release
        // down to freeing, the kernel id held at zero, unknown opcodes.
        queue_req(OP_GET,      32'd1,        8'h00, 5'd0);
        queue_req(OP_SNAPSHOT, 32'd0,        8'h00, 5'd0);
        queue_req(OP_SNAPSHOT, 32'd0,        8'h00, 5'd31);
        queue_req(OP_CREATE,   32'd0,        8'h00, 5'd0);
        queue_req(OP_CREATE,   32'd0,        8'hFF, 5'd0);
        queue_req(OP_CREATE,   32'd0,        8'h5A, 5'd0);
        queue_req(OP_FORK,     32'd1,        8'h00, 5'd0);
        queue_req(OP_FORK,     32'd2,        8'h00, 5'd0);
        queue_req(OP_RETAIN,   32'd3,        8'h00, 5'd0);
        queue_req(OP_RELEASE,  32'd3,        8'h00, 5'd0);
        queue_req(OP_RELEASE,  32'd3,        8'h00, 5'd0);
        queue_req(OP_GET,      32'd3,        8'h00, 5'd0);
        queue_req(OP_CREATE,   32'd0,        8'h80, 5'd0);
        queue_req(OP_RELEASE,  32'd1,        8'h00, 5'd0);
        queue_req(OP_RELEASE,  32'd1,        8'h00, 5'd0);
        queue_req(OP_RELEASE,  32'd1,        8'h00, 5'd0);
        queue_req(OP_GET,      32'd1,        8'h00, 5'd0);
        queue_req(OP_SNAPSHOT, 32'd0,        8'h00, 5'd1);
        queue_req(OP_SNAPSHOT, 32'd0,        8'h00, 5'd16);
        queue_req(OP_SPARE_B,  32'hFFFFFFFF, 8'hFF, 5'd31);
        queue_req(OP_SPARE_A,  32'd0,        8'h00, 5'd0);
        queue_req(OP_RETAIN,   32'hFFFFFFFF, 8'h00, 5'd0);
        queue_req(OP_FORK,     32'd0,        8'h00, 5'd0);
        queue_req(OP_RELEASE,  32'd0,        8'h00, 5'd0);
        await_quiet();

        // Back-to-back retains on the kernel space, then one step down.
        no_idle = 1'b1;
        repeat (4) queue_req(OP_RETAIN, 32'd1, 8'h00, 5'd0);
        queue_req(OP_FORK,    32'd1, 8'h00, 5'd0);
        queue_req(OP_GET,     32'd1, 8'h00, 5'd0);
        queue_req(OP_RELEASE, 32'd1, 8'h00, 5'd0);
        await_quiet();
        no_idle = 1'b0;

        // Top extremes of both registers; a create-heavy mix so the table fills.
        write_reg(REG_KERNEL_KIND, 32'hFF);
        write_reg(REG_KERNEL_ID,   32'hFFFFFFFF);
        run_phase(45, 45, 15);
        queue_req(OP_CREATE, 32'd0, 8'h11, 5'd0);
        queue_req(OP_FORK, pick_live_id(), 8'h00, 5'd0);
        await_quiet();

        // Kernel registers that match a live slot, so forks share and the
        // kernel id survives a release to zero.
        s = live_slot();
        write_reg(REG_KERNEL_KIND, (s < 0) ? 32'h00 : 32'(tbl_kind[s]));
        write_reg(REG_KERNEL_ID,   (s < 0) ? 32'd2  : tbl_id[s]);
        run_phase(45, 25, 25);

        // Bottom extremes; release-heavy so slots drain and refill.
        write_reg(REG_KERNEL_KIND, 32'h00);
        write_reg(REG_KERNEL_ID,   32'h0);
        run_phase(45, 20, 40);

        write_reg(REG_KERNEL_KIND, 32'($urandom_range(0, 255)));
        write_reg(REG_KERNEL_ID,   $urandom);
        run_phase(45, 30, 30);

        await_quiet();
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
